@@ rtl/tsgl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsgl_pkg;

   localparam int Lanes      = 8;
   localparam int SumWidth   = 48;
   localparam int FieldLanes = 8;
   localparam int ActWidth   = 16;
   localparam int WgtWidth   = 16;
   localparam int ProdWidth  = ActWidth + WgtWidth;
   localparam int ThrWidth   = 15;
   localparam int OutWidth   = 48;

   typedef struct packed {
      logic signed [ActWidth-1:0] activation;
      logic signed [WgtWidth-1:0] weight_0;
      logic signed [WgtWidth-1:0] weight_1;
      logic signed [WgtWidth-1:0] weight_2;
      logic signed [WgtWidth-1:0] weight_3;
      logic signed [WgtWidth-1:0] weight_4;
      logic signed [WgtWidth-1:0] weight_5;
      logic signed [WgtWidth-1:0] weight_6;
      logic signed [WgtWidth-1:0] weight_7;
      logic                       last_row;
   } req_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] sum_0;
      logic signed [OutWidth-1:0] sum_1;
      logic signed [OutWidth-1:0] sum_2;
      logic signed [OutWidth-1:0] sum_3;
      logic signed [OutWidth-1:0] sum_4;
      logic signed [OutWidth-1:0] sum_5;
      logic signed [OutWidth-1:0] sum_6;
      logic signed [OutWidth-1:0] sum_7;
   } rsp_type;

   typedef struct packed {
      logic load_prod;
      logic accum;
      logic clear;
   } lane_ctrl_type;

   typedef logic [Lanes-1:0][SumWidth-1:0] lane_sums_type;

endpackage

`default_nettype wire

@@ rtl/tsgl_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsgl_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tsgl_pkg::lane_ctrl_type             ctrl,
   input  wire logic signed [tsgl_pkg::ActWidth-1:0] act,
   input  wire logic signed [tsgl_pkg::WgtWidth-1:0] weight,
   output logic signed [tsgl_pkg::SumWidth-1:0]     sum_next
);
   import tsgl_pkg::*;

   localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
   localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [SumWidth-1:0]  acc_ff;
   logic signed [SumWidth-1:0]  acc_in;
   logic signed [SumWidth:0]    sum_wide;
   logic signed [SumWidth-1:0]  sum_sat;

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= act * weight;
      end
   end

   always_comb begin
      sum_wide = (SumWidth+1)'(acc_ff) + (SumWidth+1)'(prod_ff);
      if (sum_wide[SumWidth] != sum_wide[SumWidth-1]) begin
         sum_sat = sum_wide[SumWidth] ? SumMin : SumMax;
      end else begin
         sum_sat = sum_wide[SumWidth-1:0];
      end
      sum_next = ctrl.accum ? sum_sat : acc_ff;
      acc_in   = ctrl.clear ? '0 : sum_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.accum || ctrl.clear) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tsgl_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsgl_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    emit,
   input  wire tsgl_pkg::lane_sums_type sums,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output tsgl_pkg::rsp_type            rsp_data,
   output logic                         busy
);
   import tsgl_pkg::*;

   logic signed [OutWidth-1:0] out_arr [FieldLanes];
   logic                       valid_ff;
   logic                       valid_in;
   rsp_type                    data_ff;
   rsp_type                    data_in;

   for (genvar j = 0; j < FieldLanes; j++) begin : g_field
      if (j < Lanes) begin : g_used
         assign out_arr[j] = OutWidth'(signed'(sums[j]));
      end else begin : g_unused
         assign out_arr[j] = '0;
      end
   end

   always_comb begin
      data_in.sum_0 = out_arr[0];
      data_in.sum_1 = out_arr[1];
      data_in.sum_2 = out_arr[2];
      data_in.sum_3 = out_arr[3];
      data_in.sum_4 = out_arr[4];
      data_in.sum_5 = out_arr[5];
      data_in.sum_6 = out_arr[6];
      data_in.sum_7 = out_arr[7];
      valid_in = emit | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign busy      = valid_ff & rsp_stall;

endmodule

`default_nettype wire

@@ rtl/threshold_sparse_gemv_lanes_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                  Direction  Beat
// req       req_valid, req_stall, req_data         in         one row slice
// rsp       rsp_valid, rsp_stall, rsp_data         out        eight lane sums
// csr       csr_write_en, csr_write_data           in         threshold write
//
// One row slice is taken every cycle while req_stall is low; each lane has a
// registered multiplier followed by a saturating accumulator. A sum beat leaves
// through the stage-1, stage-2 and output registers after its last row is taken.
// Reset clears the threshold and all accumulators. Input stalls only while a last
// row waits behind an output beat held by rsp_stall.

module threshold_sparse_gemv_lanes_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tsgl_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tsgl_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write_en,
   input  wire logic [tsgl_pkg::ThrWidth-1:0]   csr_write_data
);
   import tsgl_pkg::*;

   logic [ThrWidth-1:0]         thr_ff;
   logic [ActWidth:0]           mag;
   logic                        use_row;
   logic                        advance;
   logic                        out_busy;
   logic                        accept;

   logic signed [WgtWidth-1:0]  w_arr [FieldLanes];

   logic                        s1_valid_ff;
   logic                        s1_use_ff;
   logic                        s1_last_ff;
   logic signed [ActWidth-1:0]  s1_act_ff;
   logic signed [WgtWidth-1:0]  s1_weight_ff [Lanes];

   logic                        s2_valid_ff;
   logic                        s2_use_ff;
   logic                        s2_last_ff;

   lane_ctrl_type               lane_ctrl;
   lane_sums_type               lane_sums;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   always_comb begin
      w_arr[0] = req_data.weight_0;
      w_arr[1] = req_data.weight_1;
      w_arr[2] = req_data.weight_2;
      w_arr[3] = req_data.weight_3;
      w_arr[4] = req_data.weight_4;
      w_arr[5] = req_data.weight_5;
      w_arr[6] = req_data.weight_6;
      w_arr[7] = req_data.weight_7;
      mag = req_data.activation[ActWidth-1]
            ? (ActWidth+1)'(-(ActWidth+1)'(req_data.activation))
            : (ActWidth+1)'(req_data.activation);
      use_row = mag > (ActWidth+1)'(thr_ff);
   end

   assign advance   = !(s2_valid_ff && s2_last_ff && out_busy);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_ff  <= use_row;
         s1_last_ff <= req_data.last_row;
         s1_act_ff  <= req_data.activation;
         for (int j = 0; j < Lanes; j++) begin
            s1_weight_ff[j] <= w_arr[j];
         end
      end
      if (advance && s1_valid_ff) begin
         s2_use_ff  <= s1_use_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      lane_ctrl.load_prod = advance && s1_valid_ff && s1_use_ff;
      lane_ctrl.accum     = advance && s2_valid_ff && s2_use_ff;
      lane_ctrl.clear     = advance && s2_valid_ff && s2_last_ff;
   end

   for (genvar j = 0; j < Lanes; j++) begin : g_lane
      tsgl_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .act      (s1_act_ff),
         .weight   (s1_weight_ff[j]),
         .sum_next (lane_sums[j])
      );
   end

   tsgl_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .emit      (lane_ctrl.clear),
      .sums      (lane_sums),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .busy      (out_busy)
   );

endmodule

`default_nettype wire

@@ tb/lane_sum_checker.sv @@
`timescale 1ns / 1ps

module lane_sum_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire tsgl_pkg::req_type             req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire tsgl_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_write_en,
   input  wire logic [tsgl_pkg::ThrWidth-1:0] csr_write_data,
   output int                                 failures,
   output int                                 outstanding
);
   import tsgl_pkg::*;

   localparam longint SumMax = (longint'(1) << (SumWidth - 1)) - 1;
   localparam longint SumMin = -SumMax - 1;

   logic [ThrWidth-1:0]        threshold;
   logic signed [SumWidth-1:0] lane_acc [Lanes];
   rsp_type                    expected_sums [$];

   function automatic void fold_row(input req_type row);
      logic [$bits(req_type)-1:0] flat;
      logic signed [WgtWidth-1:0] w;
      longint act, mag, prod, s;
      flat = row;
      act = $signed(row.activation);
      mag = (act < 0) ? -act : act;
      if (mag > longint'(threshold)) begin
         for (int j = 0; j < Lanes; j++) begin
            w = flat[(FieldLanes - 1 - j) * WgtWidth + 1 +: WgtWidth];
            prod = act * longint'(w);
            s = longint'(lane_acc[j]) + prod;
            if (s > SumMax) s = SumMax;
            else if (s < SumMin) s = SumMin;
            lane_acc[j] = s[SumWidth-1:0];
         end
      end
   endfunction

   function automatic rsp_type drain_sums();
      logic [$bits(rsp_type)-1:0] flat;
      flat = '0;
      for (int j = 0; j < Lanes; j++) begin
         flat[(FieldLanes - 1 - j) * OutWidth +: OutWidth] = lane_acc[j];
         lane_acc[j] = '0;
      end
      return rsp_type'(flat);
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      logic [$bits(rsp_type)-1:0] want_bits, got_bits;
      logic signed [OutWidth-1:0] w_lane, g_lane;
      if (expected_sums.size() == 0) begin
         note_failure("sum beat arrived with no row marked last outstanding");
         return;
      end
      want = expected_sums.pop_front();
      want_bits = want;
      got_bits = got;
      for (int j = 0; j < FieldLanes; j++) begin
         w_lane = want_bits[(FieldLanes - 1 - j) * OutWidth +: OutWidth];
         g_lane = got_bits[(FieldLanes - 1 - j) * OutWidth +: OutWidth];
         if (g_lane !== w_lane)
            note_failure($sformatf("sum_%0d mismatch: expected %0d got %0d",
                                   j, w_lane, g_lane));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold = '0;
         for (int j = 0; j < Lanes; j++) lane_acc[j] = '0;
         expected_sums.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (req_valid && !req_stall) begin
            fold_row(req_data);
            if (req_data.last_row) expected_sums.push_back(drain_sums());
         end
         if (csr_write_en) threshold = csr_write_data;
      end
      outstanding = expected_sums.size();
   end

endmodule

@@ tb/threshold_sparse_gemv_lanes_top_test.sv @@
`timescale 1ns / 1ps

module threshold_sparse_gemv_lanes_top_test;
   import tsgl_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int HoldCycles  = 400;
   localparam int SettleWait  = 8;
   localparam int SatRows     = 32;
   localparam logic [ActWidth-1:0] MostNeg = 16'h8000;
   localparam logic [ActWidth-1:0] MostPos = 16'h7FFF;
   localparam logic [ThrWidth-1:0] ThrMax  = 15'h7FFF;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_en = 1'b0;
   logic [ThrWidth-1:0] csr_write_data = '0;

   int                  fail_count;
   int                  pending;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  cycle_count = 0;
   logic                hold_go = 1'b0;
   logic                hold_off = 1'b0;
   logic [ThrWidth-1:0] thr_now = '0;

   threshold_sparse_gemv_lanes_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   lane_sum_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .failures       (fail_count),
      .outstanding    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("threshold_sparse_gemv_lanes_top_test failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // hold the sum channel off long enough for the input side to back up
   initial begin
      wait (hold_go);
      hold_off <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic req_type uniform_row(input logic [ActWidth-1:0] act,
                                           input logic [WgtWidth-1:0] w,
                                           input logic last);
      return {act, {FieldLanes{w}}, last};
   endfunction

   function automatic logic [ActWidth-1:0] pick_activation(input logic [ThrWidth-1:0] thr);
      int sel, v;
      logic [ActWidth-1:0] r;
      sel = $urandom_range(9);
      if (sel <= 5) begin
         r = 16'($urandom_range(16'hFFFF));
      end else if (sel == 6) begin
         case ($urandom_range(4))
            0: r = MostNeg;
            1: r = MostPos;
            2: r = 16'h0000;
            3: r = 16'hFFFF;
            default: r = 16'h0001;
         endcase
      end else if (sel <= 8) begin
         v = int'(thr) + $urandom_range(2) - 1;
         if ($urandom_range(1)) v = -v;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         r = v[ActWidth-1:0];
      end else begin
         v = $urandom_range(63) - 32;
         r = v[ActWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic [WgtWidth-1:0] pick_weight();
      logic [WgtWidth-1:0] w;
      if ($urandom_range(7) == 0) w = $urandom_range(1) ? MostNeg : MostPos;
      else w = 16'($urandom_range(16'hFFFF));
      return w;
   endfunction

   function automatic req_type rand_row(input logic [ThrWidth-1:0] thr, input int last_pct);
      return {pick_activation(thr),
              pick_weight(), pick_weight(), pick_weight(), pick_weight(),
              pick_weight(), pick_weight(), pick_weight(), pick_weight(),
              1'($urandom_range(99) < last_pct)};
   endfunction

   task automatic send_row(input req_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_all();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ThrWidth-1:0] value);
      req_valid <= 1'b0;
      drain_all();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      thr_now = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // random vectors, closed with a last row so no partial sums carry over
   task automatic run_vectors(input int count, input int last_pct);
      for (int i = 0; i < count; i++) send_row(rand_row(thr_now, last_pct));
      send_row(uniform_row(pick_activation(thr_now), pick_weight(), 1'b1));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 85;

      send_row(uniform_row(16'h0000, MostPos, 1'b1));
      send_row(uniform_row(MostNeg, MostNeg, 1'b0));
      send_row(uniform_row(MostNeg, MostPos, 1'b1));
      send_row({MostPos, MostPos, MostNeg, 16'h0001, 16'hFFFF,
                16'h0000, 16'h4000, 16'hC000, 16'd12345, 1'b1});
      send_row(uniform_row(16'h0001, MostNeg, 1'b0));
      send_row(uniform_row(16'hFFFF, MostPos, 1'b1));
      send_row(uniform_row(16'h0001, 16'h0001, 1'b1));

      write_threshold(15'd1000);
      send_row(uniform_row(16'd1000, MostPos, 1'b0));
      send_row(uniform_row(16'hFC18, MostNeg, 1'b0));
      send_row(uniform_row(16'd1001, 16'h1234, 1'b0));
      send_row(uniform_row(16'hFC17, 16'hEDCB, 1'b1));

      write_threshold(ThrMax);
      send_row(uniform_row(MostPos, MostPos, 1'b0));
      send_row(uniform_row(16'h8001, MostNeg, 1'b0));
      send_row(uniform_row(MostNeg, 16'h5A5A, 1'b1));

      write_threshold(15'($urandom_range(4095)));
      run_vectors(350, 16);

      send_idle_pct = 85;
      recv_idle_pct = 26;
      write_threshold(15'($urandom_range(ThrMax)));
      run_vectors(350, 16);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold('0);
      hold_go = 1'b1;
      run_vectors(250, 33);

      write_threshold(15'($urandom_range(ThrMax)));
      run_vectors(250, 16);

      // drive lanes hard in both directions, then pull the positive ones back
      write_threshold('0);
      for (int i = 0; i < SatRows; i++)
         send_row({MostNeg, MostNeg, MostNeg, MostPos, MostPos,
                   16'h0000, 16'h0001, 16'hFFFF, MostNeg, 1'b0});
      send_row(uniform_row(MostPos, MostNeg, 1'b0));
      send_row(uniform_row(16'h0000, MostPos, 1'b1));

      req_valid <= 1'b0;
      drain_all();
      if (fail_count == 0) begin
         $display("threshold_sparse_gemv_lanes_top_test passed");
      end else begin
         $display("threshold_sparse_gemv_lanes_top_test failed");
      end
      $finish;
   end

endmodule
